FILE: rtl/core/tmf_pkg.sv
// shared types, constants and width helpers of the trimmed-mean moving-average filter
// no dependencies; imported by every module of the block

package tmf_pkg;

    localparam int SAMPLE_W          = 16;
    localparam int TRIM_WINDOW_DEF   = 5;
    localparam int AVERAGE_DEPTH_DEF = 3;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // load strobes of the two divider stages
    typedef struct packed {
        logic load_abs;
        logic load_out;
    } t_div_ctl;

    // width of the full window sum
    function automatic int win_sum_w(input int trim_window);
        return SAMPLE_W + $clog2(trim_window);
    endfunction

    // width of one trimmed sum (middle entries only)
    function automatic int trim_sum_w(input int trim_window);
        return SAMPLE_W + $clog2(trim_window - 2);
    endfunction

    // width of the sum of all trimmed sums
    function automatic int total_w(input int trim_window, input int average_depth);
        return trim_sum_w(trim_window) + $clog2(average_depth);
    endfunction

endpackage

FILE: rtl/core/tmf_window.sv
// sample window stage: shifts in the new sample, registers sum, minimum and maximum
// depends on tmf_pkg

module tmf_window #(
    parameter int TRIM_WINDOW = tmf_pkg::TRIM_WINDOW_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  tmf_pkg::t_sample      i_sample,
    output logic signed [tmf_pkg::SAMPLE_W+$clog2(TRIM_WINDOW)-1:0] o_sum,
    output tmf_pkg::t_sample      o_min,
    output tmf_pkg::t_sample      o_max
);
    import tmf_pkg::*;

    localparam int SUM_W = win_sum_w(TRIM_WINDOW);

    // older samples, newest first; the incoming sample completes the window
    t_sample                  r_win [TRIM_WINDOW-1];
    t_sample                  cand  [TRIM_WINDOW];
    logic signed [SUM_W-1:0]  n_sum;
    t_sample                  n_min;
    t_sample                  n_max;
    logic signed [SUM_W-1:0]  r_sum;
    t_sample                  r_min;
    t_sample                  r_max;

    always_comb begin
        cand[0] = i_sample;
        for (int k = 1; k < TRIM_WINDOW; k++) begin
            cand[k] = r_win[k-1];
        end
    end

    always_comb begin
        n_sum = '0;
        n_min = cand[0];
        n_max = cand[0];
        for (int k = 0; k < TRIM_WINDOW; k++) begin
            n_sum = n_sum + SUM_W'(cand[k]);
            if (cand[k] < n_min) begin
                n_min = cand[k];
            end
            if (cand[k] > n_max) begin
                n_max = cand[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TRIM_WINDOW - 1; k++) begin
                r_win[k] <= '0;
            end
        end else if (i_load) begin
            r_win[0] <= i_sample;
            for (int k = 1; k < TRIM_WINDOW - 1; k++) begin
                r_win[k] <= r_win[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sum <= n_sum;
            r_min <= n_min;
            r_max <= n_max;
        end
    end

    assign o_sum = r_sum;
    assign o_min = r_min;
    assign o_max = r_max;

endmodule

FILE: rtl/core/tmf_trim_avg.sv
// trimmed sum and running total over the ring of recent trimmed sums
// depends on tmf_pkg

module tmf_trim_avg #(
    parameter int TRIM_WINDOW   = tmf_pkg::TRIM_WINDOW_DEF,
    parameter int AVERAGE_DEPTH = tmf_pkg::AVERAGE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  logic signed [tmf_pkg::SAMPLE_W+$clog2(TRIM_WINDOW)-1:0] i_sum,
    input  tmf_pkg::t_sample      i_min,
    input  tmf_pkg::t_sample      i_max,
    output logic signed [tmf_pkg::SAMPLE_W+$clog2(TRIM_WINDOW-2)
                         +$clog2(AVERAGE_DEPTH)-1:0] o_total
);
    import tmf_pkg::*;

    localparam int SUM_W  = win_sum_w(TRIM_WINDOW);
    localparam int TRIM_W = trim_sum_w(TRIM_WINDOW);
    localparam int TOT_W  = total_w(TRIM_WINDOW, AVERAGE_DEPTH);

    logic signed [TRIM_W-1:0] trim;
    logic signed [TRIM_W-1:0] r_ring [AVERAGE_DEPTH];
    logic signed [TOT_W-1:0]  r_acc;
    logic signed [TOT_W-1:0]  n_acc;

    // middle entries = whole window minus its extremes
    assign trim  = TRIM_W'(i_sum - SUM_W'(i_min) - SUM_W'(i_max));
    // running total: add newest, drop the one falling out of the ring
    assign n_acc = r_acc + TOT_W'(trim) - TOT_W'(r_ring[AVERAGE_DEPTH-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < AVERAGE_DEPTH; k++) begin
                r_ring[k] <= '0;
            end
            r_acc <= '0;
        end else if (i_load) begin
            r_ring[0] <= trim;
            for (int k = 1; k < AVERAGE_DEPTH; k++) begin
                r_ring[k] <= r_ring[k-1];
            end
            r_acc <= n_acc;
        end
    end

    assign o_total = r_acc;

endmodule

FILE: rtl/core/tmf_round_div.sv
// rounding divide of the total by the constant sample count, reciprocal multiply
// depends on tmf_pkg

module tmf_round_div #(
    parameter int TRIM_WINDOW   = tmf_pkg::TRIM_WINDOW_DEF,
    parameter int AVERAGE_DEPTH = tmf_pkg::AVERAGE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  tmf_pkg::t_div_ctl     i_ctl,
    input  logic signed [tmf_pkg::SAMPLE_W+$clog2(TRIM_WINDOW-2)
                         +$clog2(AVERAGE_DEPTH)-1:0] i_total,
    output tmf_pkg::t_sample      o_filtered
);
    import tmf_pkg::*;

    localparam int     TOT_W   = total_w(TRIM_WINDOW, AVERAGE_DEPTH);
    localparam int     DIVISOR = (TRIM_WINDOW - 2) * AVERAGE_DEPTH;
    localparam int     HALF    = DIVISOR / 2;
    localparam int     Y_W     = TOT_W + 1;
    localparam int     SHIFT   = Y_W + $clog2(DIVISOR);
    // ceiling reciprocal; exact floor for every y below 2**Y_W
    localparam longint RECIP   = ((longint'(1) << SHIFT) + DIVISOR - 1) / DIVISOR;
    localparam int     REC_W   = $clog2(RECIP + 1);
    localparam int     PROD_W  = Y_W + REC_W;

    logic                neg;
    logic [TOT_W-1:0]    mag;
    logic [Y_W-1:0]      n_y;
    logic                r_neg;
    logic [Y_W-1:0]      r_y;
    logic [PROD_W-1:0]   prod;
    logic [SAMPLE_W-1:0] quo;
    t_sample             n_out;
    t_sample             r_out;

    // magnitude plus half divisor gives round half away from zero
    assign neg = i_total[TOT_W-1];
    assign mag = neg ? TOT_W'(-i_total) : TOT_W'(i_total);
    assign n_y = Y_W'(mag) + Y_W'(HALF);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_abs) begin
            r_neg <= neg;
            r_y   <= n_y;
        end
    end

    assign prod  = PROD_W'(r_y) * PROD_W'(RECIP);
    assign quo   = prod[SHIFT +: SAMPLE_W];
    assign n_out = r_neg ? t_sample'(-quo) : t_sample'(quo);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_out) begin
            r_out <= n_out;
        end
    end

    assign o_filtered = r_out;

endmodule

FILE: rtl/core/trimmed_mean_moving_average_filter.sv
// top level of the trimmed-mean moving-average filter: handshake and stage control
// depends on tmf_pkg, tmf_window, tmf_trim_avg, tmf_round_div

// One signed sample in, one signed result out, one transaction per clock when neither
// side stalls. The last TRIM_WINDOW samples are held in a window (reset to zero, and those
// zeros count as samples, so the output ramps up after reset); the smallest and largest
// are dropped and the rest summed, and the result is the average of the last
// AVERAGE_DEPTH such trimmed sums, i.e. their total divided by
// (TRIM_WINDOW-2)*AVERAGE_DEPTH, rounded to nearest with ties away from zero. There are
// four register stages: window sum/min/max, trimmed sum and running total, magnitude and
// rounding offset, reciprocal multiply into the output register. o_valid rises when the input
// transaction has moved through these stages in order into the output register. Each stage
// holds only while everything after it is full and the output is stalled, so o_stall rises
// only with all four stages occupied and i_stall high.

module trimmed_mean_moving_average_filter #(
    parameter int TRIM_WINDOW   = tmf_pkg::TRIM_WINDOW_DEF,
    parameter int AVERAGE_DEPTH = tmf_pkg::AVERAGE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  tmf_pkg::t_sample i_sample,
    output logic             o_valid,
    input  logic             i_stall,
    output tmf_pkg::t_sample o_filtered
);
    import tmf_pkg::*;

    localparam int SUM_W = win_sum_w(TRIM_WINDOW);
    localparam int TOT_W = total_w(TRIM_WINDOW, AVERAGE_DEPTH);

    // stage occupancy
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_vo;

    // per-stage advance: a stage may load when it is empty or its content moves on
    logic en_o;
    logic en3;
    logic en2;
    logic en1;
    logic in_acc;

    logic signed [SUM_W-1:0] win_sum;
    t_sample                 win_min;
    t_sample                 win_max;
    logic signed [TOT_W-1:0] total;
    t_div_ctl                div_ctl;

    assign en_o   = !r_vo || !i_stall;
    assign en3    = !r_v3 || en_o;
    assign en2    = !r_v2 || en3;
    assign en1    = !r_v1 || en2;
    assign in_acc = i_valid && en1;

    assign o_stall = !en1;
    assign o_valid = r_vo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= in_acc;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en_o) begin
                r_vo <= r_v3;
            end
        end
    end

    // window state moves only on an input transaction
    tmf_window #(
        .TRIM_WINDOW (TRIM_WINDOW)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (in_acc),
        .i_sample (i_sample),
        .o_sum    (win_sum),
        .o_min    (win_min),
        .o_max    (win_max)
    );

    // ring of trimmed sums moves only when a real item enters the stage
    tmf_trim_avg #(
        .TRIM_WINDOW   (TRIM_WINDOW),
        .AVERAGE_DEPTH (AVERAGE_DEPTH)
    ) u_trim_avg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (en2 && r_v1),
        .i_sum   (win_sum),
        .i_min   (win_min),
        .i_max   (win_max),
        .o_total (total)
    );

    assign div_ctl.load_abs = en3 && r_v2;
    assign div_ctl.load_out = en_o && r_v3;

    tmf_round_div #(
        .TRIM_WINDOW   (TRIM_WINDOW),
        .AVERAGE_DEPTH (AVERAGE_DEPTH)
    ) u_round_div (
        .i_clk      (i_clk),
        .i_ctl      (div_ctl),
        .i_total    (total),
        .o_filtered (o_filtered)
    );

    // reset empties the output stage
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // input only stalls with every stage full and the output blocked
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && r_v3 && r_vo && i_stall))
        else $error("input stalled with a free stage");

    // an accepted transaction occupies the first stage
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_v1)
        else $error("accepted transaction lost at first stage");

    // a finished item with a free output register reaches the output
    a_last_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !(r_vo && i_stall)) |=> o_valid)
        else $error("result did not reach the output");

endmodule
